// ===== design/gaussian_kernel_density_estimator_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef GAUSSIAN_KERNEL_DENSITY_ESTIMATOR_TOP_ASSERT_SVH
`define GAUSSIAN_KERNEL_DENSITY_ESTIMATOR_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define GKDE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define GKDE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/gkde_pkg.sv =====
package gkde_pkg;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_MUL,
		ST_FIN
	} gkde_state_t;

	localparam logic [1:0] REG_PARTICLE_COUNT = 2'd0;
	localparam logic [1:0] REG_INV_H_SQUARED  = 2'd1;
	localparam logic [1:0] REG_DENSITY_SCALE  = 2'd2;

	localparam logic [10:0] PARTICLE_COUNT_RST = 11'd0;
	localparam logic [23:0] INV_H_SQUARED_RST  = 24'd65536;
	localparam logic [31:0] DENSITY_SCALE_RST  = 32'd11769;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Ratio of neighbouring exp table entries, exp(-x) in Q.32, by a Taylor series up to
	// the twelfth power of x, with alternating signs.
	function automatic logic [63:0] exp_ratio(input logic [63:0] x);
		logic [63:0] t;
		logic [63:0] q;
		begin
			t = 64'd1 << 32;
			q = 64'd1 << 32;
			t = ((t * x) >> 32) / 1;  q = q - t;
			t = ((t * x) >> 32) / 2;  q = q + t;
			t = ((t * x) >> 32) / 3;  q = q - t;
			t = ((t * x) >> 32) / 4;  q = q + t;
			t = ((t * x) >> 32) / 5;  q = q - t;
			t = ((t * x) >> 32) / 6;  q = q + t;
			t = ((t * x) >> 32) / 7;  q = q - t;
			t = ((t * x) >> 32) / 8;  q = q + t;
			t = ((t * x) >> 32) / 9;  q = q - t;
			t = ((t * x) >> 32) / 10; q = q + t;
			t = ((t * x) >> 32) / 11; q = q - t;
			t = ((t * x) >> 32) / 12; q = q + t;
			return q;
		end
	endfunction

endpackage

// ===== design/gaussian_kernel_density_estimator_top.sv =====
// Gaussian kernel density estimator: load words are taken whenever the block is idle. A query
// word over C = min(particle_count, MAX_PARTICLES) particles reads them in turn through the
// single read port of the particle memory into the kernel pipe, sums the table terms, scales
// the sum and registers it (C zero skips the pipe); no word is taken until it is registered.
// Asynchronous active-low reset clears control state; the exp table is then rebuilt,
// during which no word is accepted but configuration is.
module gaussian_kernel_density_estimator_top
	import gkde_pkg::*;
#(
	parameter int MAX_PARTICLES   = 1024,
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata fields from bit 0: slot[9:0], pos_x[33:10], pos_y[57:34], pos_z[81:58], zero pad
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,
	// s_tuser fields: mode[0]
	input  logic        s_tuser,
	// m_tdata fields: density[31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	// m_tuser fields: saturated[0]
	output logic        m_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	// Address widths of the two memories and of the particle counter.
	localparam int PAW  = MAX_PARTICLES > 1 ? $clog2(MAX_PARTICLES) : 1;
	localparam int EAW  = EXP_TABLE_DEPTH > 1 ? $clog2(EXP_TABLE_DEPTH) : 1;
	localparam int CW   = $clog2(MAX_PARTICLES + 1);
	// Accumulator holds up to MAX_PARTICLES table entries of at most 2^16 each.
	localparam int ACCW = CW + 17;
	localparam int PRW  = ACCW + 32;
	// Spacing of table arguments in Q.32 and the entry-to-entry ratio.
	localparam logic [63:0] EXP_STEP  = (64'd1 << 36) / EXP_TABLE_DEPTH;
	localparam logic [63:0] EXP_Q64   = exp_ratio(EXP_STEP);
	localparam logic [32:0] EXP_Q     = EXP_Q64[32:0];

	gkde_state_t state_q, state_d;

	// Configuration registers.
	logic [10:0] particle_count_q;
	logic [23:0] inv_h_squared_q;
	logic [31:0] density_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			particle_count_q <= PARTICLE_COUNT_RST;
			inv_h_squared_q  <= INV_H_SQUARED_RST;
			density_scale_q  <= DENSITY_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PARTICLE_COUNT: particle_count_q <= cfg_wdata[10:0];
				REG_INV_H_SQUARED:  inv_h_squared_q  <= cfg_wdata[23:0];
				REG_DENSITY_SCALE:  density_scale_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input word fields.
	logic               in_mode;
	logic [9:0]         in_slot;
	logic signed [23:0] in_x, in_y, in_z;
	logic               in_fire;

	assign in_mode = s_tuser;
	assign in_slot = s_tdata[9:0];
	assign in_x    = s_tdata[33:10];
	assign in_y    = s_tdata[57:34];
	assign in_z    = s_tdata[81:58];
	assign in_fire = s_tvalid && s_tready;

	// Effective particle count, clipped to the store size.
	logic [CW-1:0] count_eff;
	always_comb begin
		if (32'(particle_count_q) > 32'(MAX_PARTICLES)) begin
			count_eff = CW'(MAX_PARTICLES);
		end else begin
			count_eff = CW'(particle_count_q);
		end
	end

	// Exp table build: v_k follows v_{k-1} * q, rounded, one entry per cycle.
	logic [EAW:0]   init_k_q;
	logic [32:0]    init_v_q;
	logic [65:0]    init_prod;
	logic           init_last;

	assign init_prod = 66'(init_v_q) * 66'(EXP_Q) + (66'd1 << 31);
	assign init_last = (32'(init_k_q) == 32'(EXP_TABLE_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_k_q <= '0;
			init_v_q <= 33'd1 << 32;
		end else if (state_q == ST_INIT) begin
			init_k_q <= init_k_q + 1'b1;
			init_v_q <= init_prod[64:32];
		end
	end

	// Sample location and particle walk counter.
	logic signed [23:0] smp_x_q, smp_y_q, smp_z_q;
	logic [CW-1:0]      walk_q;
	logic               walk_last;

	assign walk_last = (walk_q == count_eff - 1'b1);

	always_ff @(posedge clk) begin
		if (in_fire && in_mode == MODE_QUERY) begin
			smp_x_q <= in_x;
			smp_y_q <= in_y;
			smp_z_q <= in_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (state_q == ST_IDLE) begin
			walk_q <= '0;
		end else if (state_q == ST_RUN) begin
			walk_q <= walk_q + 1'b1;
		end
	end

	// Particle memory.
	logic           pm_we;
	logic [PAW-1:0] pm_raddr;
	logic [71:0]    pm_rdata;

	assign pm_we    = in_fire && in_mode == MODE_LOAD && (32'(in_slot) < 32'(MAX_PARTICLES));
	assign pm_raddr = walk_q[PAW-1:0];

	gkde_ram #(.WIDTH(72), .DEPTH(MAX_PARTICLES)) u_particles (
		.clk   (clk),
		.we    (pm_we),
		.waddr (PAW'(in_slot)),
		.wdata ({in_z, in_y, in_x}),
		.raddr (pm_raddr),
		.rdata (pm_rdata)
	);

	// Exp table memory.
	logic [EAW-1:0] et_raddr;
	logic [16:0]    et_rdata;
	logic [32:0]    init_entry;

	assign init_entry = init_v_q + 33'(1 << 15);

	gkde_ram #(.WIDTH(17), .DEPTH(EXP_TABLE_DEPTH)) u_exp_table (
		.clk   (clk),
		.we    (state_q == ST_INIT),
		.waddr (init_k_q[EAW-1:0]),
		.wdata (init_entry[32:16]),
		.raddr (et_raddr),
		.rdata (et_rdata)
	);

	// Kernel pipe. Stage 1 is the particle read, stage 6 the table read.
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic               hit_s6;
	logic signed [24:0] dx_s2, dy_s2, dz_s2;
	logic [49:0]        sqx_s3, sqy_s3, sqz_s3;
	logic [35:0]        r2s_s4;
	logic [59:0]        u_s5;
	logic [51:0]        r2_sum;
	logic [52:0]        idx_prod;
	logic               pipe_busy;

	assign r2_sum    = 52'(sqx_s3) + 52'(sqy_s3) + 52'(sqz_s3);
	assign idx_prod  = 53'(u_s5[35:0]) * 53'(EXP_TABLE_DEPTH);
	assign et_raddr  = idx_prod[36 +: EAW];
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= 25'(smp_x_q) - 25'(signed'(pm_rdata[23:0]));
		dy_s2  <= 25'(smp_y_q) - 25'(signed'(pm_rdata[47:24]));
		dz_s2  <= 25'(smp_z_q) - 25'(signed'(pm_rdata[71:48]));
		sqx_s3 <= 50'(dx_s2 * dx_s2);
		sqy_s3 <= 50'(dy_s2 * dy_s2);
		sqz_s3 <= 50'(dz_s2 * dz_s2);
		r2s_s4 <= r2_sum[51:16];
		u_s5   <= 60'(r2s_s4) * 60'(inv_h_squared_q);
		// Terms at u of sixteen or more contribute nothing.
		hit_s6 <= (u_s5[59:36] == '0);
	end

	// Accumulator and final scaling.
	logic [ACCW-1:0] acc_q;
	logic [PRW-1:0]  prod_q;
	logic            out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (state_q == ST_IDLE) begin
			acc_q <= '0;
		end else if (v_s6 && hit_s6) begin
			acc_q <= acc_q + ACCW'(et_rdata);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= PRW'(acc_q) * PRW'(density_scale_q);
		end
	end

	// Output register, so a finished word can wait while loads are taken.
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			if (prod_q[PRW-1:48] != '0) begin
				m_tdata <= 32'hFFFF_FFFF;
				m_tuser <= 1'b1;
			end else begin
				m_tdata <= prod_q[47:16];
				m_tuser <= 1'b0;
			end
		end
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (init_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_fire && in_mode == MODE_QUERY) begin
					state_d = (count_eff == '0) ? ST_MUL : ST_RUN;
				end
			end
			ST_RUN: begin
				if (walk_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!pipe_busy) state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== design/gkde_ram.sv =====
module gkde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/gkde_checker.sv =====
`include "gaussian_kernel_density_estimator_top_assert.svh"

module gkde_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);
	`GKDE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped")
	`GKDE_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed")
	`GKDE_ASSERT_SAME(a_sat_max, m_tvalid && m_tuser, m_tdata == 32'hFFFF_FFFF, "bad saturation")
	`GKDE_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && s_tuser, !s_tready, "query overlap")
endmodule

bind gaussian_kernel_density_estimator_top gkde_checker u_gkde_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
